### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                      mode;
        logic signed [KEY_W-1:0]    new_key;
        logic signed [VALUE_W-1:0]  new_value;
    } t_req;

    typedef struct packed {
        logic signed [KEY_W-1:0]    head_key;
        logic signed [VALUE_W-1:0]  head_value;
        logic                       queue_empty;
        logic [COUNT_OUT_W-1:0]     entry_count;
        logic                       op_error;
    } t_rsp;

    typedef struct packed {
        logic signed [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic    shift_in;
        logic    shift_out;
        t_entry  new_entry;
    } t_cell_ctl;

endpackage

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares the incoming key against its own
// entry and takes the new entry, its left neighbor or its right neighbor, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_place,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output logic               o_place,
    output spq_pkg::t_entry    o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // strictly less keeps equal keys in arrival order
    assign o_place = !i_occupied || (i_ctl.new_entry.key < r_entry.key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_in) begin
            if (i_left_place) begin
                n_entry = i_left;
            end else if (o_place) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.shift_out) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted key/value priority queue built as a shift chain of compare cells.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge has its result on o_rsp, marked by
// o_done, during the following cycle, and busy stays low so a new request
// may be issued in every cycle. In the cell chain each cell compares the
// new key with its own entry in parallel and shifts by one slot. The
// result shows the head entry, the count and an error flag after the
// request; an insert into a full queue or a removal from an empty one is
// dropped with op_error set. The receiver cannot stall: o_done marks each
// result for one cycle only.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::t_req i_req,
    output logic          o_done,
    output spq_pkg::t_rsp o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             r_err;
    logic             n_err;

    logic               accept;
    logic               full;
    logic               empty;
    spq_pkg::t_cell_ctl cell_ctl;

    spq_pkg::t_entry cell_entry [CAPACITY];
    logic            cell_place [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);

    always_comb begin
        cell_ctl.shift_in        = accept && (i_req.mode == spq_pkg::MODE_INSERT) && !full;
        cell_ctl.shift_out       = accept && (i_req.mode == spq_pkg::MODE_REMOVE) && !empty;
        cell_ctl.new_entry.key   = i_req.new_key;
        cell_ctl.new_entry.value = i_req.new_value;
    end

    always_comb begin
        n_count = r_count;
        if (cell_ctl.shift_in) begin
            n_count = r_count + 1'b1;
        end else if (cell_ctl.shift_out) begin
            n_count = r_count - 1'b1;
        end
        n_err = accept && !cell_ctl.shift_in && !cell_ctl.shift_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
            if (accept) begin
                r_err <= n_err;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            left_place;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        if (g == 0) begin : g_first
            assign left_place  = 1'b0;
            assign left_entry  = cell_ctl.new_entry;
        end else begin : g_mid
            assign left_place  = cell_place[g-1];
            assign left_entry  = cell_entry[g-1];
        end

        // last slot refills with its own entry; it is beyond the count after a removal
        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[g];
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_left_place (left_place),
            .i_left       (left_entry),
            .i_right      (right_entry),
            .o_place      (cell_place[g]),
            .o_entry      (cell_entry[g])
        );
    end

    always_comb begin
        o_rsp.head_key    = empty ? '0 : cell_entry[0].key;
        o_rsp.head_value  = empty ? '0 : cell_entry[0].value;
        o_rsp.queue_empty = empty;
        o_rsp.entry_count = spq_pkg::COUNT_OUT_W'(r_count);
        o_rsp.op_error    = r_err;
    end

    assign o_done = r_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("request without result strobe");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.shift_in |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_err) |=> (r_count == $past(r_count)) && o_rsp.op_error)
        else $error("dropped request changed the queue");

endmodule
